>>> design/lpht_pkg.sv
// Shared constants, codes and types of the linear-probing hash table.
package lpht_pkg;

   localparam int TABLE_DEPTH = 1024;  // power of two: home slot is the low hash bits
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int HASH_BITS   = 32;
   localparam int COUNT_BITS  = 11;

   localparam logic [COUNT_BITS-1:0] FILL_LIMIT_RESET = COUNT_BITS'(768);
   localparam logic [ADDR_BITS-1:0]  LAST_STEP        = ADDR_BITS'(TABLE_DEPTH - 1);

   localparam logic [1:0] CMD_FIND   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      logic                  occupied;
      logic                  deleted;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      slot_type wr_data;
      addr_type rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [1:0]            command;
      logic [KEY_BITS-1:0]   key;
      logic [HASH_BITS-1:0]  key_hash;
      logic [VALUE_BITS-1:0] value;
   } request_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] found_value;
      logic [COUNT_BITS-1:0] live_count;
   } result_type;

endpackage

>>> design/lpht_slot_ram.sv
// Slot memory: one write port and one registered read port.
module lpht_slot_ram (
   input  logic                 clock,
   input  lpht_pkg::ram_req_type ram_req,
   output lpht_pkg::slot_type    rd_data_ff
);
   import lpht_pkg::*;

   slot_type slot_mem_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         slot_mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= slot_mem_ff[ram_req.rd_addr];
   end

endmodule

>>> design/lpht_probe_ctrl.sv
// Probe sequencer: clearing pass, linear probe over the slot memory, commit.
module lpht_probe_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lpht_pkg::request_type         req,
   input  logic [lpht_pkg::COUNT_BITS-1:0] fill_limit,
   output logic                          res_valid,
   input  logic                          res_ready,
   output lpht_pkg::result_type          result,
   output lpht_pkg::ram_req_type         ram_req,
   input  lpht_pkg::slot_type            rd_data
);
   import lpht_pkg::*;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE, S_FINISH} state_type;

   state_type             state_ff;
   addr_type              addr_ff;
   addr_type              step_ff;
   logic [1:0]            cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff;
   addr_type              match_addr_ff;
   logic [VALUE_BITS-1:0] match_value_ff;
   logic                  free_ff;
   addr_type              free_addr_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic                  accept;
   logic                  slot_hit;
   logic                  slot_empty;
   logic                  commit;
   logic                  over_limit;
   logic [COUNT_BITS-1:0] count_in;
   slot_type              fin_data;
   addr_type              fin_addr;
   logic                  fin_write;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign slot_hit   = rd_data.occupied && (rd_data.key == key_ff);
   assign slot_empty = !rd_data.occupied && !rd_data.deleted;
   assign res_valid  = (state_ff == S_FINISH);
   assign commit     = res_valid && res_ready;
   assign over_limit = ({1'b0, count_ff} + (COUNT_BITS+1)'(1)) > {1'b0, fill_limit};

   // Outcome of the finished probe.
   always_comb begin
      result.status      = STATUS_NOT_FOUND;
      result.found_value = '0;
      count_in           = count_ff;
      fin_write          = 1'b0;
      fin_addr           = match_addr_ff;
      fin_data           = '{occupied: 1'b0, deleted: 1'b1, key: key_ff, value: value_ff};
      case (cmd_ff)
         CMD_FIND: begin
            if (match_ff) begin
               result.status      = STATUS_DONE;
               result.found_value = match_value_ff;
            end
         end
         CMD_INSERT: begin
            if (match_ff) begin
               result.status = STATUS_DUPLICATE;
            end else if (over_limit || !free_ff) begin
               result.status = STATUS_FULL;
            end else begin
               result.status = STATUS_DONE;
               fin_write     = 1'b1;
               fin_addr      = free_addr_ff;
               fin_data      = '{occupied: 1'b1, deleted: 1'b0, key: key_ff, value: value_ff};
               count_in      = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_DELETE: begin
            if (match_ff) begin
               result.status = STATUS_DONE;
               fin_write     = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_BITS'(1);
               end
            end
         end
         default: begin
            result.status = STATUS_NOT_FOUND;
         end
      endcase
      result.live_count = count_in;
   end

   // Memory port: the clearing pass and the commit write, reads run one slot ahead.
   always_comb begin
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = fin_addr;
      ram_req.wr_data = fin_data;
      ram_req.rd_addr = req.key_hash[ADDR_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = '0;
         end
         S_PROBE: begin
            ram_req.rd_addr = addr_ff + ADDR_BITS'(1);
         end
         S_FINISH: begin
            ram_req.wr_en = commit && fin_write;
         end
         default: begin
            ram_req.wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + ADDR_BITS'(1);
               if (addr_ff == LAST_STEP) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req.command;
                  key_ff   <= req.key;
                  value_ff <= req.value;
                  addr_ff  <= req.key_hash[ADDR_BITS-1:0];
                  step_ff  <= '0;
                  match_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  if (req.command == CMD_FIND || req.command == CMD_INSERT ||
                      req.command == CMD_DELETE) begin
                     state_ff <= S_PROBE;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_PROBE: begin
               if (!rd_data.occupied && !free_ff) begin
                  free_ff      <= 1'b1;
                  free_addr_ff <= addr_ff;
               end
               if (slot_hit) begin
                  match_ff       <= 1'b1;
                  match_addr_ff  <= addr_ff;
                  match_value_ff <= rd_data.value;
                  state_ff       <= S_FINISH;
               end else if (slot_empty || step_ff == LAST_STEP) begin
                  state_ff <= S_FINISH;
               end else begin
                  addr_ff <= addr_ff + ADDR_BITS'(1);
                  step_ff <= step_ff + ADDR_BITS'(1);
               end
            end
            S_FINISH: begin
               if (commit) begin
                  count_ff <= count_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> design/linear_probe_hash_table_core.sv
// Top level of the linear-probing hash table: stream ports, fill limit, response register.
//
// Open-addressing hash table of 1024 key/value slots with linear probing and
// tombstone deletion. Each request carries a command (find, insert, delete),
// a key, the key's hash (home slot = low 10 hash bits) and a value; each
// request yields exactly one response with a status, the found value and the
// live entry count. After reset the block runs a clearing pass over all 1024
// slots of the slot memory and accepts no request until it ends; fill-limit
// writes are taken at any time. A find, insert or delete request then runs
// in order: accept it and issue the home-slot read, examine the probed slots
// one per cycle through the single read port of the slot memory, then commit
// the update and load the response register. A probe ends at a matching key,
// at a never-used slot, or after a full pass. The response register lets the
// next request be accepted while a response still waits to be taken; the
// following commit holds until it is taken.
module linear_probe_hash_table_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [103:0]                      req_tdata,   // command, key, key_hash, value, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,   // status, found_value, live_count, zero pad
   input  logic                              csr_wr_en,
   input  logic [lpht_pkg::COUNT_BITS-1:0]   csr_wr_data
);
   import lpht_pkg::*;

   logic [COUNT_BITS-1:0] fill_limit_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_result_ff;

   request_type req;
   result_type  result;
   logic        res_valid;
   logic        res_ready;
   ram_req_type ram_req;
   slot_type    rd_data;

   // Unpack the request fields from the lowest bit up.
   assign req.command  = req_tdata[1:0];
   assign req.key      = req_tdata[33:2];
   assign req.key_hash = req_tdata[65:34];
   assign req.value    = req_tdata[97:66];

   // The response register is free when empty or being drained this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   lpht_probe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .fill_limit (fill_limit_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .result     (result),
      .ram_req    (ram_req),
      .rd_data    (rd_data)
   );

   lpht_slot_ram u_ram (
      .clock      (clock),
      .ram_req    (ram_req),
      .rd_data_ff (rd_data)
   );

   // Hold the fill limit; load it on every configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= FILL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         fill_limit_ff <= csr_wr_data;
      end
   end

   // Response register: load on commit, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_result_ff.live_count, rsp_result_ff.found_value,
                        rsp_result_ff.status};

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the linear-probing hash table core.
module testbench;
   import lpht_pkg::*;

   // Command code that the block must ignore.
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         POOL_SIZE   = 24;
   localparam int         CYCLE_LIMIT = 4_000_000;

   // Tracks the table contents and queues the response that each request should produce.
   class hash_table_scoreboard;
      logic [KEY_BITS-1:0]   slot_key   [TABLE_DEPTH];
      logic [VALUE_BITS-1:0] slot_value [TABLE_DEPTH];
      bit                    slot_used  [TABLE_DEPTH];
      bit                    slot_tomb  [TABLE_DEPTH];
      int                    live;
      int                    fill_limit;
      result_type            expected_responses[$];
      int                    error_count;

      function new();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_tomb[i] = 1'b0;
         end
         live        = 0;
         fill_limit  = int'(FILL_LIMIT_RESET);
         error_count = 0;
      endfunction

      function void set_fill_limit(logic [COUNT_BITS-1:0] limit);
         fill_limit = int'(limit);
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function int live_entries();
         return live;
      endfunction

      // Slot holding the key, or -1; stop at a never-used slot or after one full pass.
      function int locate_key(logic [KEY_BITS-1:0] k, addr_type home);
         addr_type a;
         a = home;
         for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[a] && !slot_tomb[a])
               return -1;
            if (slot_used[a] && slot_key[a] == k)
               return int'(a);
            a = a + 1'b1;
         end
         return -1;
      endfunction

      // First tombstone or empty slot on the probe path, or -1.
      function int first_free(addr_type home);
         addr_type a;
         a = home;
         for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[a])
               return int'(a);
            a = a + 1'b1;
         end
         return -1;
      endfunction

      function void note_request(request_type r);
         result_type res;
         addr_type   home;
         int         pos;
         home            = r.key_hash[ADDR_BITS-1:0];
         res.status      = STATUS_NOT_FOUND;
         res.found_value = '0;
         case (r.command)
            CMD_FIND: begin
               pos = locate_key(r.key, home);
               if (pos >= 0) begin
                  res.status      = STATUS_DONE;
                  res.found_value = slot_value[pos];
               end
            end
            CMD_INSERT: begin
               // Duplicate check comes before the fill check.
               if (locate_key(r.key, home) >= 0) begin
                  res.status = STATUS_DUPLICATE;
               end else if (live + 1 > fill_limit) begin
                  res.status = STATUS_FULL;
               end else begin
                  pos = first_free(home);
                  if (pos < 0) begin
                     res.status = STATUS_FULL;
                  end else begin
                     slot_key[pos]   = r.key;
                     slot_value[pos] = r.value;
                     slot_used[pos]  = 1'b1;
                     slot_tomb[pos]  = 1'b0;
                     live++;
                     res.status = STATUS_DONE;
                  end
               end
            end
            CMD_DELETE: begin
               pos = locate_key(r.key, home);
               if (pos >= 0) begin
                  slot_used[pos] = 1'b0;
                  slot_tomb[pos] = 1'b1;
                  if (live > 0)
                     live--;
                  res.status = STATUS_DONE;
               end
            end
            default: begin
            end
         endcase
         res.live_count = COUNT_BITS'(live);
         expected_responses.push_back(res);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d value %h count %0d",
                     $time, got.status, got.found_value, got.live_count);
            error_count++;
            return;
         end
         want = expected_responses.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
         end
         if (got.found_value !== want.found_value) begin
            $display("%0t: found_value mismatch, expected %h, actual %h",
                     $time, want.found_value, got.found_value);
            error_count++;
         end
         if (got.live_count !== want.live_count) begin
            $display("%0t: live_count mismatch, expected %0d, actual %0d",
                     $time, want.live_count, got.live_count);
            error_count++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [103:0]          req_tdata   = '0;   // command, key, key_hash, value, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [47:0]           rsp_tdata;          // status, found_value, live_count, zero pad
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   hash_table_scoreboard sb;
   int                   sender_idle_pct    = 0;
   int                   receiver_stall_pct = 0;
   int                   cycle_count        = 0;
   result_type           observed;
   logic [KEY_BITS-1:0]  fill_key;
   logic [HASH_BITS-1:0] first_fill_hash;
   addr_type             next_home;

   linear_probe_hash_table_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check every response taken.
   assign observed.status      = rsp_tdata[1:0];
   assign observed.found_value = rsp_tdata[33:2];
   assign observed.live_count  = rsp_tdata[44:34];

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(observed);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [HASH_BITS-1:0] make_hash(addr_type home);
      logic [HASH_BITS-1:0] h;
      h                 = $urandom();
      h[ADDR_BITS-1:0]  = home;
      return h;
   endfunction

   // Present one request, hold it until accepted, then idle at random.
   task automatic send_request(input request_type r);
      int gap;
      req_tdata  <= {6'b0, r.value, r.key_hash, r.key, r.command};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_BITS-1:0] k,
                           input logic [HASH_BITS-1:0] h, input logic [VALUE_BITS-1:0] v);
      request_type r;
      r.command  = cmd;
      r.key      = k;
      r.key_hash = h;
      r.value    = v;
      send_request(r);
   endtask

   // Drop valid and wait until every outstanding response is back.
   task automatic drain_responses();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
   endtask

   task automatic write_fill_limit(input logic [COUNT_BITS-1:0] limit);
      drain_responses();
      csr_wr_data <= limit;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_fill_limit(limit);
   endtask

   // Mostly well-formed traffic on a small key pool clustered around one home window.
   task automatic run_random_phase(input int items, input addr_type base,
                                   input logic [COUNT_BITS-1:0] limit,
                                   input int send_idle, input int recv_stall);
      logic [KEY_BITS-1:0]  pool_key  [POOL_SIZE];
      logic [HASH_BITS-1:0] pool_hash [POOL_SIZE];
      request_type          r;
      int                   idx;
      int                   pick;
      write_fill_limit(limit);
      sender_idle_pct    = send_idle;
      receiver_stall_pct = recv_stall;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i]  = $urandom();
         pool_hash[i] = make_hash(base + addr_type'($urandom_range(15)));
      end
      for (int n = 0; n < items; n++) begin
         idx     = $urandom_range(POOL_SIZE - 1);
         r.value = $urandom();
         if ($urandom_range(99) < 85) begin
            r.key      = pool_key[idx];
            r.key_hash = pool_hash[idx];
            pick       = $urandom_range(99);
            if (pick < 40)
               r.command = CMD_INSERT;
            else if (pick < 75)
               r.command = CMD_FIND;
            else if (pick < 95)
               r.command = CMD_DELETE;
            else
               r.command = CMD_UNUSED;
         end else begin
            // Noise: any command, random hash, sometimes a pool key under the wrong hash.
            r.command  = 2'($urandom_range(3));
            r.key      = $urandom_range(1) ? pool_key[idx] : KEY_BITS'($urandom());
            r.key_hash = $urandom();
         end
         send_request(r);
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, wrap at the table end, tombstones, ignored command.
      send_cmd(CMD_FIND,   '0, '0, '0);
      send_cmd(CMD_DELETE, '1, '1, '1);
      send_cmd(CMD_INSERT, '0, '0, '1);
      send_cmd(CMD_INSERT, '1, '1, '0);
      send_cmd(CMD_INSERT, 32'd1, 32'h0000_03FF, 32'h1234_5678);
      send_cmd(CMD_FIND,   32'd1, 32'hFFFF_FFFF, '0);
      send_cmd(CMD_INSERT, '0, 32'hABCD_EC00, 32'h5555_5555);
      send_cmd(CMD_DELETE, '1, '1, '0);
      send_cmd(CMD_FIND,   32'd1, 32'h0000_03FF, '0);
      send_cmd(CMD_FIND,   '1, '1, '0);
      send_cmd(CMD_INSERT, 32'd2, 32'h0000_03FF, 32'hAAAA_AAAA);
      send_cmd(CMD_UNUSED, 32'd2, 32'h0000_03FF, '1);
      send_cmd(CMD_FIND,   32'hA5A5_A5A5, 32'h5A5A_5800, '0);
      send_cmd(CMD_FIND,   '0, '0, '0);

      // Fill limit: zero refuses all, then tight limits.
      write_fill_limit(COUNT_BITS'(0));
      send_cmd(CMD_INSERT, 32'd3, 32'd5, 32'hDEAD_BEEF);
      write_fill_limit(COUNT_BITS'(1));
      send_cmd(CMD_INSERT, 32'd3, 32'd5, 32'hDEAD_BEEF);
      write_fill_limit(COUNT_BITS'(4));
      send_cmd(CMD_INSERT, 32'd3, 32'd5, 32'hDEAD_BEEF);
      send_cmd(CMD_INSERT, 32'd4, 32'd6, 32'h0BAD_F00D);
      send_cmd(CMD_INSERT, '0, '0, 32'd7);
      send_cmd(CMD_DELETE, 32'd3, 32'd5, '0);

      // Random traffic under each idling mode; one window sits at the table end.
      run_random_phase(240, addr_type'($urandom_range(TABLE_DEPTH - 1)), COUNT_BITS'(1024), 0, 0);
      run_random_phase(240, addr_type'(TABLE_DEPTH - 8), COUNT_BITS'(12), 64, 0);
      run_random_phase(240, addr_type'($urandom_range(TABLE_DEPTH - 1)), COUNT_BITS'(768), 0, 64);
      run_random_phase(240, addr_type'($urandom_range(TABLE_DEPTH - 1)), COUNT_BITS'(25), 21, 21);

      // Fill every slot with the limit above the table size, then probe the full table.
      write_fill_limit(COUNT_BITS'(2047));
      fill_key        = 32'h8000_0000;
      next_home       = '0;
      first_fill_hash = make_hash(next_home);
      while (sb.live_entries() < TABLE_DEPTH) begin
         send_cmd(CMD_INSERT, fill_key,
                  (fill_key == 32'h8000_0000) ? first_fill_hash : make_hash(next_home),
                  $urandom());
         fill_key  = fill_key + 1'b1;
         next_home = next_home + 1'b1;
      end
      send_cmd(CMD_INSERT, 32'h7FFF_FFFF, make_hash(addr_type'(37)), '1);
      send_cmd(CMD_FIND,   32'h7FFF_FFFE, make_hash(addr_type'(900)), '0);
      send_cmd(CMD_FIND,   32'h8000_0000, first_fill_hash, '0);
      send_cmd(CMD_DELETE, 32'h8000_0000, first_fill_hash, '0);
      send_cmd(CMD_INSERT, 32'h7FFF_FFFF, make_hash(addr_type'(512)), '0);
      write_fill_limit(COUNT_BITS'(1024));
      send_cmd(CMD_INSERT, 32'h7FFF_FFFD, make_hash(addr_type'(3)), '0);

      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
